[design/sle_pkg.sv]
`timescale 1ns / 1ps
// Package for the string literal unescape block: transaction types, command codes,
// character constants and the hex digit decoder. No dependencies.
package sle_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
        logic [1:0] literal_kind;
    } sle_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       bad_literal;
        logic       last_of_run;
    } sle_out_t;

    typedef logic [1:0] sle_op_t;

    localparam sle_op_t OP_BYTE   = 2'd0;
    localparam sle_op_t OP_UTF8   = 2'd1;
    localparam sle_op_t OP_STATUS = 2'd2;

    // One command from the parser: a plain byte, a code point to encode, or a status.
    typedef struct packed {
        sle_op_t     op;
        logic        bad;
        logic [20:0] value;
    } sle_cmd_t;

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_RAW    = 2'd1;

    localparam logic [20:0] CP_MAX    = 21'h10ffff;
    localparam logic [20:0] SURR_LO   = 21'h00d800;
    localparam logic [20:0] SURR_HI   = 21'h00dfff;
    localparam logic [20:0] UTF8_MAX1 = 21'h00007f;
    localparam logic [20:0] UTF8_MAX2 = 21'h0007ff;
    localparam logic [20:0] UTF8_MAX3 = 21'h00ffff;

    localparam logic [7:0] LEAD2     = 8'hc0;
    localparam logic [7:0] LEAD3     = 8'he0;
    localparam logic [7:0] LEAD4     = 8'hf0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Returns {valid, value}.
    function automatic logic [4:0] hex_to_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[design/sle_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel with a typed payload, used for all streams of the block.
// No dependencies; the payload type is given at instantiation.
interface sle_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/sle_front.sv]
`timescale 1ns / 1ps
// Parser: tracks the token and escape state and turns each input byte into at most
// one command. Depends on sle_pkg and sle_stream_if.
module sle_front
    import sle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sle_stream_if.sink   in_ch,
    sle_stream_if.source cmd
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_BODY  = 3'd1;
    localparam logic [2:0] MODE_ESC   = 3'd2;
    localparam logic [2:0] MODE_HEX1  = 3'd3;
    localparam logic [2:0] MODE_HEX2  = 3'd4;
    localparam logic [2:0] MODE_UOPEN = 3'd5;
    localparam logic [2:0] MODE_UDIG  = 3'd6;

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  kind_reg, kind_next;
    logic [3:0]  hex_high_reg, hex_high_next;
    logic [20:0] cp_reg, cp_next;
    logic        seen_reg, seen_next;
    logic        failed_reg, failed_next;

    logic        emit;
    sle_cmd_t    cmd_data;
    logic        accept;
    logic [7:0]  c;
    logic [4:0]  hd;
    logic [24:0] cp_shift;

    assign c        = in_ch.data.in_byte;
    assign hd       = hex_to_nibble(c);
    assign cp_shift = {cp_reg, hd[3:0]};
    assign accept   = in_ch.valid && in_ch.ready;

    assign in_ch.ready = cmd.ready;
    assign cmd.valid   = in_ch.valid && emit;
    assign cmd.data    = cmd_data;

    always_comb
    begin
        mode_next     = mode_reg;
        kind_next     = kind_reg;
        hex_high_next = hex_high_reg;
        cp_next       = cp_reg;
        seen_next     = seen_reg;
        failed_next   = failed_reg;
        emit          = 1'b0;
        cmd_data.op    = OP_BYTE;
        cmd_data.bad   = 1'b0;
        cmd_data.value = {13'd0, c};

        if (in_ch.data.first_byte)
        begin
            kind_next     = in_ch.data.literal_kind;
            mode_next     = MODE_BODY;
            hex_high_next = 4'd0;
            cp_next       = 21'd0;
            seen_next     = 1'b0;
            failed_next   = (in_ch.data.literal_kind > KIND_RAW);
            if (in_ch.data.last_byte)
            begin
                // A token of a single byte has no closing delimiter of its own.
                emit           = 1'b1;
                cmd_data.op    = OP_STATUS;
                cmd_data.bad   = 1'b1;
                cmd_data.value = 21'd0;
                mode_next      = MODE_IDLE;
                kind_next      = 2'd0;
                failed_next    = 1'b0;
            end
        end
        else if (mode_reg == MODE_IDLE)
        begin
            emit = 1'b0;
        end
        else if (in_ch.data.last_byte)
        begin
            emit           = 1'b1;
            cmd_data.op    = OP_STATUS;
            cmd_data.bad   = failed_reg || (mode_reg != MODE_BODY);
            cmd_data.value = 21'd0;
            mode_next      = MODE_IDLE;
            kind_next      = 2'd0;
            hex_high_next  = 4'd0;
            cp_next        = 21'd0;
            seen_next      = 1'b0;
            failed_next    = 1'b0;
        end
        else if (!failed_reg)
        begin
            if (kind_reg == KIND_RAW)
            begin
                emit = 1'b1;
            end
            else
            begin
                case (mode_reg)
                    MODE_BODY:
                    begin
                        if (c == CH_BSLASH)
                            mode_next = MODE_ESC;
                        else
                            emit = 1'b1;
                    end
                    MODE_ESC:
                    begin
                        mode_next = MODE_BODY;
                        case (c)
                            CH_BSLASH, CH_DQUOTE, CH_SQUOTE: emit = 1'b1;
                            CH_N:
                            begin
                                emit           = 1'b1;
                                cmd_data.value = {13'd0, CH_LF};
                            end
                            CH_R:
                            begin
                                emit           = 1'b1;
                                cmd_data.value = {13'd0, CH_CR};
                            end
                            CH_T:
                            begin
                                emit           = 1'b1;
                                cmd_data.value = {13'd0, CH_TAB};
                            end
                            CH_ZERO:
                            begin
                                emit           = 1'b1;
                                cmd_data.value = {13'd0, CH_NUL};
                            end
                            CH_X: mode_next = MODE_HEX1;
                            CH_U: mode_next = MODE_UOPEN;
                            default: failed_next = 1'b1;
                        endcase
                    end
                    MODE_HEX1:
                    begin
                        if (!hd[4])
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            hex_high_next = hd[3:0];
                            mode_next     = MODE_HEX2;
                        end
                    end
                    MODE_HEX2:
                    begin
                        if (!hd[4])
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            emit           = 1'b1;
                            cmd_data.value = {13'd0, hex_high_reg, hd[3:0]};
                            hex_high_next  = 4'd0;
                            mode_next      = MODE_BODY;
                        end
                    end
                    MODE_UOPEN:
                    begin
                        if (c != CH_LBRACE)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            cp_next   = 21'd0;
                            seen_next = 1'b0;
                            mode_next = MODE_UDIG;
                        end
                    end
                    MODE_UDIG:
                    begin
                        if (c == CH_RBRACE)
                        begin
                            if (!seen_reg || (cp_reg >= SURR_LO && cp_reg <= SURR_HI))
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                emit           = 1'b1;
                                cmd_data.op    = OP_UTF8;
                                cmd_data.value = cp_reg;
                                cp_next        = 21'd0;
                                seen_next      = 1'b0;
                                mode_next      = MODE_BODY;
                            end
                        end
                        else if (!hd[4])
                        begin
                            failed_next = 1'b1;
                        end
                        else if (cp_shift > {4'd0, CP_MAX})
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            cp_next   = cp_shift[20:0];
                            seen_next = 1'b1;
                        end
                    end
                    default: failed_next = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            kind_reg     <= 2'd0;
            hex_high_reg <= 4'd0;
            cp_reg       <= 21'd0;
            seen_reg     <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            kind_reg     <= kind_next;
            hex_high_reg <= hex_high_next;
            cp_reg       <= cp_next;
            seen_reg     <= seen_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

[design/sle_queue.sv]
`timescale 1ns / 1ps
// Command queue between parser and output stage, built from registers.
// Depends on sle_pkg and sle_stream_if.
module sle_queue
    import sle_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    sle_stream_if.sink   wr,
    sle_stream_if.source rd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sle_cmd_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign wr.ready = (count_reg != CW'(DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.data  = mem[rd_ptr_reg];
    assign push     = wr.valid && wr.ready;
    assign pop      = rd.valid && rd.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr.data;
    end

endmodule

[design/sle_back.sv]
`timescale 1ns / 1ps
// Output stage: expands each queued command into one to four result transactions,
// doing the UTF-8 encoding. Depends on sle_pkg and sle_stream_if.
module sle_back
    import sle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sle_stream_if.sink   cmd,
    sle_stream_if.source out_ch
);

    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  n_minus1;
    logic [7:0]  seq [4];
    logic [20:0] v;
    logic        final_byte;
    sle_out_t    res;

    assign v = cmd.data.value;

    always_comb
    begin
        n_minus1 = 2'd0;
        if (cmd.data.op == OP_UTF8)
        begin
            if (v <= UTF8_MAX1)
                n_minus1 = 2'd0;
            else if (v <= UTF8_MAX2)
                n_minus1 = 2'd1;
            else if (v <= UTF8_MAX3)
                n_minus1 = 2'd2;
            else
                n_minus1 = 2'd3;
        end
    end

    always_comb
    begin
        seq[0] = v[7:0];
        seq[1] = 8'd0;
        seq[2] = 8'd0;
        seq[3] = 8'd0;
        case (n_minus1)
            2'd1:
            begin
                seq[0] = LEAD2 | {3'd0, v[10:6]};
                seq[1] = CONT_MARK | {2'd0, v[5:0]};
            end
            2'd2:
            begin
                seq[0] = LEAD3 | {4'd0, v[15:12]};
                seq[1] = CONT_MARK | {2'd0, v[11:6]};
                seq[2] = CONT_MARK | {2'd0, v[5:0]};
            end
            2'd3:
            begin
                seq[0] = LEAD4 | {5'd0, v[20:18]};
                seq[1] = CONT_MARK | {2'd0, v[17:12]};
                seq[2] = CONT_MARK | {2'd0, v[11:6]};
                seq[3] = CONT_MARK | {2'd0, v[5:0]};
            end
            default: seq[0] = v[7:0];
        endcase
    end

    assign final_byte = (idx_reg == n_minus1);

    always_comb
    begin
        res.last_of_run = final_byte;
        if (cmd.data.op == OP_STATUS)
        begin
            res.out_byte    = 8'd0;
            res.is_status   = 1'b1;
            res.bad_literal = cmd.data.bad;
        end
        else
        begin
            res.out_byte    = seq[idx_reg];
            res.is_status   = 1'b0;
            res.bad_literal = 1'b0;
        end
    end

    assign out_ch.valid = cmd.valid;
    assign out_ch.data  = res;
    assign cmd.ready    = out_ch.ready && final_byte;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_ch.valid && out_ch.ready)
            idx_next = final_byte ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

[design/string_literal_unescape_core.sv]
`timescale 1ns / 1ps
// Top level of the string literal unescape block: parser, command queue and output stage.
// Depends on sle_pkg, sle_stream_if, sle_front, sle_queue and sle_back.

// The block takes one byte of a literal token per cycle while the command queue has room and
// returns the decoded bytes, then one status transaction at the closing delimiter. The
// parser turns each input byte combinationally into at most one command, registered in the
// queue; the output stage gives a command's results one at a time, so a \u{...} escape
// yields one to four results and a status or plain byte one. Since an escape always spans
// at least as many input bytes as it yields, a steady stream runs at one byte per cycle
// while the output takes all results; the QUEUE_DEPTH queue absorbs bursts and output stalls.
module string_literal_unescape_core
    import sle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    sle_stream_if.sink   in_stream,
    sle_stream_if.source out_stream
);

    sle_stream_if #(.T(sle_cmd_t)) cmd_push ();
    sle_stream_if #(.T(sle_cmd_t)) cmd_pop ();

    sle_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_stream),
        .cmd   (cmd_push)
    );

    sle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .rd    (cmd_pop)
    );

    sle_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_pop),
        .out_ch (out_stream)
    );

    // A status transaction is always the single, all-zero-data result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_stream.valid && out_stream.data.is_status
        |-> out_stream.data.last_of_run && (out_stream.data.out_byte == 8'd0))
        else $error("status result malformed");

    // Data results never carry the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_stream.valid && !out_stream.data.is_status |-> !out_stream.data.bad_literal)
        else $error("error flag on a data result");

    // A command leaves the queue only with the final result it causes.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop.valid && cmd_pop.ready
        |-> out_stream.valid && out_stream.ready && out_stream.data.last_of_run)
        else $error("command retired without its final result");

endmodule
